// File: hw/rtl/tmr_pkg.sv
package tmr_pkg;

    localparam int NUM_TILES    = 256;
    localparam int MAX_TILE_DIM = 16;
    localparam int MAP_DIM      = 256;

    // index widths derived from the store geometry
    localparam int TILE_W     = $clog2(NUM_TILES);
    localparam int PIX_W      = $clog2(MAX_TILE_DIM);
    localparam int MAP_W      = $clog2(MAP_DIM);
    localparam int ICON_AW    = TILE_W + 2 * PIX_W;
    localparam int MAP_AW     = 2 * MAP_W;
    localparam int ICON_DEPTH = NUM_TILES * MAX_TILE_DIM * MAX_TILE_DIM;
    localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;

    // fixed field widths
    localparam int DIM_W  = 5;
    localparam int CODE_W = 8;
    localparam int COL_W  = 8;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 8;

    typedef enum logic [1:0] {
        OP_LOAD_PIXEL = 2'd0,
        OP_LOAD_CELL  = 2'd1,
        OP_RENDER     = 2'd2,
        OP_EXPORT     = 2'd3
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TILE_WIDTH   = 3'd0,
        CFG_TILE_HEIGHT  = 3'd1,
        CFG_TRANSPARENCY = 3'd2,
        CFG_BLANK_COLOR  = 3'd3,
        CFG_KNOWN_ZERO   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] code;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  x;
        logic [COL_W-1:0]  color;
    } t_icon_wr;

    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  x;
    } t_icon_rd;

    typedef struct packed {
        logic [COL_W-1:0] pix_a;
        logic [COL_W-1:0] pix_b;
        logic             def_a;
        logic             def_b;
    } t_icon_rsp;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] cell_addr;
        logic [CODE_W-1:0] base;
        logic [CODE_W-1:0] over;
    } t_map_wr;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] cell_addr;
    } t_map_rd;

    function automatic logic code_ok(input logic [CODE_W-1:0] code);
        return {1'b0, code} < (CODE_W + 1)'(NUM_TILES);
    endfunction

    function automatic logic [ICON_AW-1:0] icon_addr(input logic [CODE_W-1:0] code,
                                                     input logic [PIX_W-1:0] y,
                                                     input logic [PIX_W-1:0] x);
        return {code[TILE_W-1:0], y, x};
    endfunction

endpackage

// File: hw/rtl/tmr_icon_store.sv
module tmr_icon_store
    import tmr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_icon_wr  i_wr,
    input  t_icon_rd  i_rd,
    output t_icon_rsp o_rsp
);

    logic [COL_W-1:0] r_mem [ICON_DEPTH];
    logic [NUM_TILES-1:0] r_defined;
    t_icon_rsp r_rsp;

    // pixel memory, one write and two reads per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[icon_addr(i_wr.code, i_wr.y, i_wr.x)] <= i_wr.color;
        end
        if (i_rd.en) begin
            r_rsp.pix_a <= r_mem[icon_addr(i_rd.code_a, i_rd.y, i_rd.x)];
            r_rsp.pix_b <= r_mem[icon_addr(i_rd.code_b, i_rd.y, i_rd.x)];
            r_rsp.def_a <= code_ok(i_rd.code_a) && r_defined[i_rd.code_a[TILE_W-1:0]];
            r_rsp.def_b <= code_ok(i_rd.code_b) && r_defined[i_rd.code_b[TILE_W-1:0]];
        end
    end

    // defined flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defined <= '0;
        end else if (i_wr.en) begin
            r_defined[i_wr.code[TILE_W-1:0]] <= 1'b1;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: hw/rtl/tmr_map_store.sv
module tmr_map_store
    import tmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_wr           i_wr,
    input  t_map_rd           i_rd,
    output logic [CODE_W-1:0] o_base,
    output logic [CODE_W-1:0] o_over,
    output logic              o_busy
);

    logic [2*CODE_W-1:0] r_mem [MAP_DEPTH];
    logic [2*CODE_W-1:0] r_rdata;
    logic                r_clr_busy;
    logic [MAP_AW-1:0]   r_clr_addr;

    logic                we;
    logic [MAP_AW-1:0]   waddr;
    logic [2*CODE_W-1:0] wdata;

    // clearing pass owns the write port after reset
    always_comb begin
        we    = r_clr_busy || i_wr.en;
        waddr = r_clr_busy ? r_clr_addr : i_wr.cell_addr;
        wdata = r_clr_busy ? '0 : {i_wr.base, i_wr.over};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_base = r_rdata[2*CODE_W-1:CODE_W];
    assign o_over = r_rdata[CODE_W-1:0];
    assign o_busy = r_clr_busy;

endmodule

// File: hw/rtl/tile_map_renderer_overlay.sv
// tile map renderer with overlay
//
// input channel (i_valid / o_ready) carries one operation per transfer:
// load icon pixel, load map cell, render slice, export cell. loads are
// written in the transfer cycle and produce nothing. a render slice with an
// in-range cell and row gives tile_width (clamped to 1..16) pixel
// transfers on the output channel (o_valid / i_ready), the final one
// flagged by o_last; an export gives one transfer with o_last set.
// render or export: the map word is read in the transfer cycle, then the
// sequencer steps one icon column per cycle while the output is not
// stalled, through the dual-read icon memory and a single select/compare
// unit; a pixel passes the map word, icon read and output registers.
// o_ready stays low until an item's last value enters the output register.
// a stalled receiver holds the output register; the sequencer stops issuing
// reads until the output frees up, so nothing is dropped.
// after reset the map overlay store is cleared one cell a cycle, with
// o_ready low; configuration writes are taken at any time.
module tile_map_renderer_overlay
    import tmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_icon_index,
    input  logic [3:0]        i_pixel_x,
    input  logic [3:0]        i_pixel_y,
    input  logic [7:0]        i_color,
    input  logic [7:0]        i_cell_x,
    input  logic [7:0]        i_cell_y,
    input  logic [7:0]        i_base_code,
    input  logic [7:0]        i_overlay_code,
    // output channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_value,
    output logic              o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [DIM_W-1:0] r_tile_width, n_tile_width;
    logic [DIM_W-1:0] r_tile_height, n_tile_height;
    logic [COL_W-1:0] r_transp, n_transp;
    logic [COL_W-1:0] r_blank, n_blank;
    logic             r_kaz, n_kaz;

    // per-item context
    logic             r_export, n_export;
    logic             r_cell_ok, n_cell_ok;
    logic [PIX_W-1:0] r_py, n_py;
    logic [DIM_W-1:0] r_w, n_w;
    logic [PIX_W-1:0] r_x, n_x;

    // read data stage and output register
    logic             r_d_v, n_d_v;
    logic             r_d_last, n_d_last;
    logic             r_o_valid, n_o_valid;
    logic [COL_W-1:0] r_o_value, n_o_value;
    logic             r_o_last, n_o_last;

    t_icon_wr  icon_wr;
    t_icon_rd  icon_rd;
    t_icon_rsp icon_rsp;
    t_map_wr   map_wr;
    t_map_rd   map_rd;
    logic [CODE_W-1:0] map_base, map_over;
    logic              clr_busy;

    logic             accept;
    logic             cell_in_ok;
    logic [MAP_AW-1:0] cell_in;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             out_free;
    logic             issue;
    logic             is_last;
    logic [COL_W-1:0] base_pix, over_pix, pix_val, exp_val, d_val;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (v > DIM_W'(MAX_TILE_DIM)) begin
            return DIM_W'(MAX_TILE_DIM);
        end
        return v;
    endfunction

    tmr_icon_store u_icon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (icon_wr),
        .i_rd    (icon_rd),
        .o_rsp   (icon_rsp)
    );

    tmr_map_store u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (map_wr),
        .i_rd    (map_rd),
        .o_base  (map_base),
        .o_over  (map_over),
        .o_busy  (clr_busy)
    );

    assign o_ready  = (r_state == S_IDLE) && !clr_busy;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        cell_in_ok = ({1'b0, i_cell_x} < 9'(MAP_DIM)) && ({1'b0, i_cell_y} < 9'(MAP_DIM));
        cell_in    = {i_cell_y[MAP_W-1:0], i_cell_x[MAP_W-1:0]};
        w_eff      = clamp_dim(r_tile_width);
        h_eff      = clamp_dim(r_tile_height);
    end

    // store ports: loads are written straight from the transfer
    always_comb begin
        icon_wr.en    = accept && (t_op'(i_op) == OP_LOAD_PIXEL)
                        && code_ok(i_icon_index)
                        && ({1'b0, i_pixel_x} < 5'(MAX_TILE_DIM))
                        && ({1'b0, i_pixel_y} < 5'(MAX_TILE_DIM));
        icon_wr.code  = i_icon_index;
        icon_wr.y     = i_pixel_y[PIX_W-1:0];
        icon_wr.x     = i_pixel_x[PIX_W-1:0];
        icon_wr.color = i_color;

        map_wr.en        = accept && (t_op'(i_op) == OP_LOAD_CELL) && cell_in_ok;
        map_wr.cell_addr = cell_in;
        map_wr.base      = i_base_code;
        map_wr.over      = i_overlay_code;

        map_rd.en        = accept && ((t_op'(i_op) == OP_RENDER) || (t_op'(i_op) == OP_EXPORT));
        map_rd.cell_addr = cell_in_ok ? cell_in : '0;
    end

    // column sequencer: a read is issued when the data stage will be free
    always_comb begin
        issue          = (r_state == S_RUN) && (!r_d_v || out_free);
        is_last        = (DIM_W'(r_x) + DIM_W'(1)) == r_w;
        icon_rd.en     = issue;
        icon_rd.code_a = map_base;
        icon_rd.code_b = map_over;
        icon_rd.y      = r_py;
        icon_rd.x      = r_x;
    end

    // shared select/compare unit
    always_comb begin
        base_pix = icon_rsp.def_a ? icon_rsp.pix_a : r_blank;
        over_pix = icon_rsp.def_b ? icon_rsp.pix_b : r_blank;
        pix_val  = base_pix;
        if ((map_over != '0) && (over_pix != r_transp)) begin
            pix_val = over_pix;
        end
        exp_val = '0;
        if (r_cell_ok && !(r_kaz && icon_rsp.def_a)) begin
            exp_val = map_base;
        end
        d_val = r_export ? exp_val : pix_val;
    end

    always_comb begin
        n_state       = r_state;
        n_tile_width  = r_tile_width;
        n_tile_height = r_tile_height;
        n_transp      = r_transp;
        n_blank       = r_blank;
        n_kaz         = r_kaz;
        n_export      = r_export;
        n_cell_ok     = r_cell_ok;
        n_py          = r_py;
        n_w           = r_w;
        n_x           = r_x;
        n_d_v         = r_d_v;
        n_d_last      = r_d_last;
        n_o_valid     = r_o_valid;
        n_o_value     = r_o_value;
        n_o_last      = r_o_last;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TILE_WIDTH:   n_tile_width  = i_cfg_data[DIM_W-1:0];
                CFG_TILE_HEIGHT:  n_tile_height = i_cfg_data[DIM_W-1:0];
                CFG_TRANSPARENCY: n_transp      = i_cfg_data[COL_W-1:0];
                CFG_BLANK_COLOR:  n_blank       = i_cfg_data[COL_W-1:0];
                CFG_KNOWN_ZERO:   n_kaz         = i_cfg_data[0];
                default:          ;
            endcase
        end

        // output register takes the data stage whenever it frees up
        if (out_free) begin
            n_o_valid = r_d_v;
            if (r_d_v) begin
                n_o_value = d_val;
                n_o_last  = r_d_last;
            end
            n_d_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_export  = (t_op'(i_op) == OP_EXPORT);
                    n_cell_ok = cell_in_ok;
                    n_py      = i_pixel_y[PIX_W-1:0];
                    n_x       = '0;
                    n_w       = (t_op'(i_op) == OP_EXPORT) ? DIM_W'(1) : w_eff;
                    if (t_op'(i_op) == OP_EXPORT) begin
                        n_state = S_RUN;
                    end else if ((t_op'(i_op) == OP_RENDER) && cell_in_ok
                                 && ({1'b0, i_pixel_y} < h_eff)) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_d_v    = 1'b1;
                    n_d_last = is_last;
                    n_x      = r_x + 1'b1;
                    if (is_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tile_width  <= DIM_W'(8);
            r_tile_height <= DIM_W'(8);
            r_transp      <= '0;
            r_blank       <= COL_W'(8);
            r_kaz         <= 1'b0;
            r_d_v         <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tile_width  <= n_tile_width;
            r_tile_height <= n_tile_height;
            r_transp      <= n_transp;
            r_blank       <= n_blank;
            r_kaz         <= n_kaz;
            r_d_v         <= n_d_v;
            r_o_valid     <= n_o_valid;
        end
        r_export  <= n_export;
        r_cell_ok <= n_cell_ok;
        r_py      <= n_py;
        r_w       <= n_w;
        r_x       <= n_x;
        r_d_last  <= n_d_last;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
    end

    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;

endmodule
